// ----- design/opbtb_pkg.sv -----
// Package with types, constants and helper functions for the partitioned branch target buffer.
`default_nettype none
package opbtb_pkg;

  localparam int LargeSets  = 512;
  localparam int SmallSets  = 64;
  localparam int RasDepth   = 64;
  localparam int CallSizes  = 1024;
  localparam int NumParts   = 9;
  localparam int LargeBits  = $clog2(LargeSets);
  localparam int SmallBits  = $clog2(SmallSets);
  localparam int TotalSets  = 8 * LargeSets + SmallSets;
  localparam int SlotBits   = $clog2(TotalSets);
  localparam int PartBits   = $clog2(NumParts);
  localparam int RasBits    = $clog2(RasDepth);
  localparam int CsBits     = $clog2(CallSizes);

  localparam logic [2:0] KindNone     = 3'd0;
  localparam logic [2:0] KindCond     = 3'd3;
  localparam logic [2:0] KindCall     = 3'd4;
  localparam logic [2:0] KindIndCall  = 3'd5;
  localparam logic [2:0] KindReturn   = 3'd6;

  typedef struct packed {
    logic        func;
    logic [63:0] fetch_address;
    logic [2:0]  branch_kind;
    logic [63:0] resolved_target;
    logic        was_taken;
  } opbtb_in_t;

  typedef struct packed {
    logic [63:0] predicted_target;
    logic [2:0]  predicted_kind;
    logic        lookup_missed;
  } opbtb_out_t;

  // One stored branch entry, valid bit included.
  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [2:0]  kind;
    logic [63:0] target;
    logic [63:0] age;
  } opbtb_entry_t;

  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StCheck, StRas, StWrite
  } opbtb_state_e;

  // Number of index bits of a partition.
  function automatic int unsigned part_ibits(input logic [PartBits-1:0] p);
    return (p < PartBits'(8)) ? LargeBits : SmallBits;
  endfunction

  function automatic logic [15:0] make_tag(input logic [PartBits-1:0] p,
                                           input logic [63:0] ip);
    logic [63:0] a;
    logic [7:0]  fold;
    a = (ip >> 2) >> part_ibits(p);
    fold = '0;
    for (int i = 1; i < 8; i++) begin
      fold = fold ^ a[8*i +: 8];
    end
    return {fold, a[7:0]};
  endfunction

  // Slot of the primary or secondary set of a partition.
  function automatic logic [SlotBits-1:0] slot_of(input logic [PartBits-1:0] p,
                                                  input logic [63:0] ip,
                                                  input logic sec);
    logic [SlotBits-1:0] idx;
    logic [SlotBits-1:0] base;
    if (p < PartBits'(8)) begin
      idx = SlotBits'(ip[2 +: LargeBits]);
      if (sec) idx[LargeBits-1] = ~idx[LargeBits-1];
    end else begin
      idx = SlotBits'(ip[2 +: SmallBits]);
      if (sec) idx[SmallBits-1] = ~idx[SmallBits-1];
    end
    base = SlotBits'(p) * SlotBits'(LargeSets);
    return base + idx;
  endfunction

  function automatic logic [PartBits-1:0] start_part(input logic [6:0] nb);
    if (nb == 7'd0) return PartBits'(0);
    if (nb <= 7'd4) return PartBits'(1);
    if (nb <= 7'd5) return PartBits'(2);
    if (nb <= 7'd7) return PartBits'(3);
    if (nb <= 7'd9) return PartBits'(4);
    if (nb <= 7'd11) return PartBits'(5);
    if (nb <= 7'd19) return PartBits'(6);
    if (nb <= 7'd25) return PartBits'(7);
    return PartBits'(8);
  endfunction

endpackage
`default_nettype wire

// ----- design/opbtb_entry_ram.sv -----
// Entry memory of all partitions with one read and one write port.
`default_nettype none
module opbtb_entry_ram
  import opbtb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [SlotBits-1:0] rd_addr_i,
  output      opbtb_entry_t        rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [SlotBits-1:0] wr_addr_i,
  input  wire opbtb_entry_t        wr_data_i
);

  opbtb_entry_t mem_q [TotalSets];

  // Synchronous read and write of the entries.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

// ----- design/offset_partitioned_branch_target_buffer.sv -----
// Top level of the offset-partitioned branch target buffer with return stack.
//
// Channel  Direction  Handshake                  Beat
// in       input      in_valid_i / in_ready_o    opbtb_in_t
// out      output     out_valid_o / out_ready_i  opbtb_out_t
//
// The eighteen candidate slots are read one per cycle through the entry memory port,
// then come a check state and a write-back state; a new beat is accepted only after the
// previous one is written back. A taken update that misses scans again from its start
// partition. After reset a clearing pass empties the entries and the stack and sets
// every call size to four; the input is not ready until it ends.
// A result waits in the output register while the next beat is read; that beat's
// write-back stalls until the register is free.
`default_nettype none
module offset_partitioned_branch_target_buffer
  import opbtb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire opbtb_in_t  in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      opbtb_out_t out_data_o
);

  opbtb_state_e state_q, state_d;
  opbtb_in_t    req_q;
  logic [PartBits-1:0] part_q, part_d;
  logic         sec_q, sec_d;
  logic         pend_q;              // read issued last cycle
  logic         hit_q;
  logic [SlotBits-1:0] hit_slot_q;
  opbtb_entry_t hit_ent_q;
  logic         scan_q;              // 0 hit search, 1 victim search
  logic [SlotBits-1:0] best_slot_q, cand_slot_q;
  logic [PartBits-1:0] best_part_q, cand_part_q;
  logic [63:0]  best_age_q;
  logic         have_best_q;
  logic [63:0]  age_cnt_q;
  logic [SlotBits-1:0] clr_q;        // position of the clearing pass
  logic [63:0]  ras_q [RasDepth];
  logic [63:0]  ras_top_q;
  logic [RasBits-1:0] rsp_q;
  logic [3:0]   cs_q [CallSizes];
  logic [3:0]   cs_top_q;
  opbtb_out_t   out_q;
  logic         out_v_q;

  logic [SlotBits-1:0] rd_addr;
  opbtb_entry_t rd_data;
  logic         wr_en;
  logic [SlotBits-1:0] wr_addr;
  opbtb_entry_t wr_data;
  logic [63:0]  rd_age;
  logic         cmp_hit;
  logic         commit;
  logic [2:0]   eff_kind;
  logic         is_call;
  logic [RasBits-1:0] push_ptr;
  logic [63:0]  ret_dist;
  logic         ras_we;
  logic [RasBits-1:0] ras_wa;
  logic [63:0]  ras_wd;
  logic         cs_we;
  logic [CsBits-1:0] cs_wa;
  logic [3:0]   cs_wd;
  logic [6:0]   nbits;
  logic [63:0]  diff;

  opbtb_entry_ram u_ram (
    .clk_i,
    .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign rd_addr     = slot_of(part_q, req_q.fetch_address, sec_q);
  assign rd_age      = rd_data.valid ? rd_data.age : 64'd0;
  assign commit      = (state_q == StWrite) && (!out_v_q || out_ready_i);

  // Tag match of the slot read in the previous cycle during the hit search.
  assign cmp_hit = pend_q && !scan_q && !hit_q && rd_data.valid &&
                   (rd_data.tag == make_tag(cand_part_q, req_q.fetch_address));

  // Bit length of the shifted offset for the start partition.
  always_comb begin
    diff  = (req_q.resolved_target >> 2) ^ (req_q.fetch_address >> 2);
    nbits = '0;
    for (int i = 0; i < 64; i++) begin
      if (diff[i]) nbits = 7'(i + 1);
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    part_d  = part_q;
    sec_d   = sec_q;
    case (state_q)
      StClear: begin
        if (clr_q == SlotBits'(TotalSets - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          state_d = StRead;
          part_d  = '0;
          sec_d   = 1'b0;
        end
      end
      StRead: begin
        // Walk all slots; stop issuing after the last.
        if (sec_q && part_q == PartBits'(NumParts - 1)) begin
          state_d = StCheck;
        end else begin
          sec_d = ~sec_q;
          if (sec_q) part_d = part_q + PartBits'(1);
        end
      end
      StCheck: begin
        if (!scan_q && !hit_q && !cmp_hit && req_q.func && req_q.was_taken) begin
          state_d = StRas;
        end else begin
          state_d = StWrite;
        end
      end
      StRas: begin
        state_d = StRead;
        part_d  = (req_q.branch_kind == KindReturn) ? '0 : start_part(nbits);
        sec_d   = 1'b0;
      end
      StWrite: begin
        if (commit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Entry write on a taken update, or an empty entry during the clearing pass.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_slot_q;
    wr_data = hit_ent_q;
    if (state_q == StClear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (commit && req_q.func && req_q.was_taken) begin
      if (hit_q) begin
        wr_en          = 1'b1;
        wr_data.kind   = req_q.branch_kind;
        if (req_q.resolved_target != 64'd0) wr_data.target = req_q.resolved_target;
        wr_data.age    = age_cnt_q;
      end else if (req_q.resolved_target != 64'd0) begin
        wr_en          = 1'b1;
        wr_addr        = best_slot_q;
        wr_data.valid  = 1'b1;
        wr_data.tag    = make_tag(best_part_q, req_q.fetch_address);
        wr_data.kind   = req_q.branch_kind;
        wr_data.target = req_q.resolved_target;
        wr_data.age    = age_cnt_q;
      end
    end
  end

  // Return stack and call size writes of the committed beat or the clearing pass.
  always_comb begin
    eff_kind = hit_q ? hit_ent_q.kind : req_q.branch_kind;
    is_call  = (eff_kind == KindCall) || (eff_kind == KindIndCall);
    push_ptr = rsp_q + RasBits'(1);
    ret_dist = (ras_top_q > req_q.resolved_target) ? ras_top_q - req_q.resolved_target
                                                   : req_q.resolved_target - ras_top_q;
    ras_we   = 1'b0;
    ras_wa   = push_ptr;
    ras_wd   = req_q.fetch_address;
    cs_we    = 1'b0;
    cs_wa    = ras_top_q[CsBits-1:0];
    cs_wd    = ret_dist[3:0];
    if (state_q == StClear) begin
      ras_we = (clr_q < SlotBits'(RasDepth));
      ras_wa = clr_q[RasBits-1:0];
      ras_wd = '0;
      cs_we  = (clr_q < SlotBits'(CallSizes));
      cs_wa  = clr_q[CsBits-1:0];
      cs_wd  = 4'd4;
    end else if (commit) begin
      if (!req_q.func) begin
        ras_we = is_call;
      end else if (req_q.branch_kind == KindReturn) begin
        // A pop clears the slot it reads.
        ras_we = 1'b1;
        ras_wa = rsp_q;
        ras_wd = '0;
        cs_we  = (ret_dist <= 64'd10);
      end
    end
  end

  // Return stack memory; the top is read every cycle.
  always_ff @(posedge clk_i) begin
    if (ras_we) ras_q[ras_wa] <= ras_wd;
    ras_top_q <= ras_q[rsp_q];
  end

  // Call size memory, read at the registered stack top.
  always_ff @(posedge clk_i) begin
    if (cs_we) cs_q[cs_wa] <= cs_wd;
    cs_top_q <= cs_q[ras_top_q[CsBits-1:0]];
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) req_q <= in_data_i;
    if (state_q == StIdle) begin
      hit_ent_q <= '0;
    end
    if (cmp_hit) begin
      hit_slot_q <= cand_slot_q;
      hit_ent_q  <= rd_data;
    end
    if (pend_q && scan_q) begin
      // Strict compare keeps the earlier slot on ties.
      if (!have_best_q || rd_age < best_age_q) begin
        best_age_q  <= rd_age;
        best_slot_q <= cand_slot_q;
        best_part_q <= cand_part_q;
      end
    end
    cand_slot_q <= rd_addr;
    cand_part_q <= part_q;
  end

  // Control registers, stack pointer, age counter and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      part_q      <= '0;
      sec_q       <= 1'b0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      scan_q      <= 1'b0;
      have_best_q <= 1'b0;
      age_cnt_q   <= '0;
      clr_q       <= '0;
      rsp_q       <= '0;
      out_v_q     <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
      sec_q   <= sec_d;
      pend_q  <= (state_q == StRead);
      if (state_q == StClear) clr_q <= clr_q + SlotBits'(1);
      if (state_q == StIdle) begin
        hit_q       <= 1'b0;
        scan_q      <= 1'b0;
        have_best_q <= 1'b0;
      end
      if (cmp_hit) hit_q <= 1'b1;
      if (pend_q && scan_q) have_best_q <= 1'b1;
      if (state_q == StRas) scan_q <= 1'b1;
      if (commit) begin
        out_v_q <= 1'b1;
        if (!req_q.func) begin
          // Predict: push calls, form the result.
          if (is_call) rsp_q <= push_ptr;
          if (!hit_q) begin
            out_q <= '{predicted_target: 64'd0, predicted_kind: KindCond,
                       lookup_missed: 1'b1};
          end else if (eff_kind == KindReturn) begin
            out_q <= '{predicted_target: ras_top_q + 64'(cs_top_q),
                       predicted_kind: eff_kind, lookup_missed: 1'b0};
          end else begin
            out_q <= '{predicted_target: hit_ent_q.target, predicted_kind: eff_kind,
                       lookup_missed: 1'b0};
          end
        end else begin
          if (req_q.branch_kind == KindReturn) rsp_q <= rsp_q - RasBits'(1);
          if (req_q.was_taken) age_cnt_q <= age_cnt_q + 64'd1;
          out_q <= '{predicted_target: 64'd0, predicted_kind: KindNone,
                     lookup_missed: 1'b0};
        end
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_offset_partitioned_branch_target_buffer.sv -----
// Self-checking testbench for the offset-partitioned branch target buffer with return stack.
module tb_offset_partitioned_branch_target_buffer;
  import opbtb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats = 1150;
  localparam int CycleLimit  = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  opbtb_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  opbtb_out_t out_data_o;

  offset_partitioned_branch_target_buffer DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // Predictor state: a shadow copy of the buffer contents.
  bit          shadow_valid [TotalSets];
  logic [15:0] shadow_tag   [TotalSets];
  logic [2:0]  shadow_kind  [TotalSets];
  logic [63:0] shadow_tgt   [TotalSets];
  logic [63:0] shadow_age   [TotalSets];
  logic [63:0] ras_mem      [RasDepth];
  int unsigned ras_ptr;
  logic [3:0]  call_size    [CallSizes];
  logic [63:0] age_count;

  opbtb_in_t  pending_beats[$];
  opbtb_out_t expected_results[$];
  int         errors = 0;
  int         cycles = 0;
  int         checked = 0;
  bit         stim_done = 1'b0;
  bit         hold_sink = 1'b0;
  bit         quiet = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned ibits_of(int p);
    return (p < 8) ? $clog2(LargeSets) : $clog2(SmallSets);
  endfunction

  function automatic logic [15:0] tag_for(int p, logic [63:0] ip);
    logic [63:0] a;
    logic [7:0]  fold;
    a = (ip >> 2) >> ibits_of(p);
    fold = '0;
    for (int i = 1; i < 8; i++) fold ^= a[8*i +: 8];
    return {fold, a[7:0]};
  endfunction

  function automatic int set_slot(int p, logic [63:0] ip, bit sec);
    int sets;
    int idx;
    sets = (p < 8) ? LargeSets : SmallSets;
    idx = int'((ip >> 2) & 64'(sets - 1));
    if (sec) idx = idx ^ (sets / 2);
    return p * LargeSets + idx;
  endfunction

  function automatic logic [63:0] age_at(int k);
    return shadow_valid[k] ? shadow_age[k] : 64'd0;
  endfunction

  function automatic int lookup_slot(logic [63:0] ip);
    int k;
    for (int p = 0; p < NumParts; p++) begin
      for (int s = 0; s < 2; s++) begin
        k = set_slot(p, ip, s[0]);
        if (shadow_valid[k] && shadow_tag[k] == tag_for(p, ip)) return k;
      end
    end
    return -1;
  endfunction

  function automatic int first_part(int nb);
    if (nb == 0) return 0;
    if (nb <= 4) return 1;
    if (nb <= 5) return 2;
    if (nb <= 7) return 3;
    if (nb <= 9) return 4;
    if (nb <= 11) return 5;
    if (nb <= 19) return 6;
    if (nb <= 25) return 7;
    return 8;
  endfunction

  function automatic void push_return(logic [63:0] ip);
    ras_ptr = (ras_ptr + 1) % RasDepth;
    ras_mem[ras_ptr] = ip;
  endfunction

  // Append one beat to the pending queue.
  function automatic void queue_beat(opbtb_in_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // Advance the shadow buffer by one beat and return the answer it gives.
  function automatic opbtb_out_t predict_btb(opbtb_in_t b);
    opbtb_out_t  r;
    int          hit;
    logic [2:0]  kd;
    logic [63:0] top, cip, d, diff;
    int          nb, start, best_p, best_k, ka, kb, kc;
    logic [63:0] best_age, ag;
    r = '0;
    hit = lookup_slot(b.fetch_address);
    kd = b.branch_kind;
    if (b.func == 1'b0) begin
      if (hit < 0) begin
        if (kd == KindCall || kd == KindIndCall) push_return(b.fetch_address);
        r.predicted_kind = KindCond;
        r.lookup_missed = 1'b1;
        return r;
      end
      kd = shadow_kind[hit];
      if (kd == KindCall || kd == KindIndCall) push_return(b.fetch_address);
      if (kd == KindReturn) begin
        top = ras_mem[ras_ptr];
        r.predicted_target = top + 64'(call_size[top % CallSizes]);
      end else begin
        r.predicted_target = shadow_tgt[hit];
      end
      r.predicted_kind = kd;
      return r;
    end
    // Returns pop the stack and may learn a call size.
    if (kd == KindReturn) begin
      cip = ras_mem[ras_ptr];
      ras_mem[ras_ptr] = '0;
      ras_ptr = (ras_ptr == 0) ? RasDepth - 1 : ras_ptr - 1;
      d = (cip > b.resolved_target) ? cip - b.resolved_target : b.resolved_target - cip;
      if (d <= 64'd10) call_size[cip % CallSizes] = d[3:0];
    end
    if (!b.was_taken) return r;
    if (hit >= 0) begin
      shadow_kind[hit] = kd;
      if (b.resolved_target != 0) shadow_tgt[hit] = b.resolved_target;
      shadow_age[hit] = age_count;
    end else begin
      nb = 0;
      if (kd != KindReturn) begin
        diff = (b.resolved_target >> 2) ^ (b.fetch_address >> 2);
        while (diff != 0) begin
          diff >>= 1;
          nb++;
        end
      end
      start = first_part(nb);
      best_p = start;
      best_k = set_slot(start, b.fetch_address, 1'b0);
      best_age = age_at(best_k);
      kb = set_slot(start, b.fetch_address, 1'b1);
      if (age_at(kb) < best_age) begin
        best_k = kb;
        best_age = age_at(kb);
      end
      // Oldest slot over the later partitions, ties kept earlier.
      for (int p = start + 1; p < NumParts; p++) begin
        ka = set_slot(p, b.fetch_address, 1'b0);
        kb = set_slot(p, b.fetch_address, 1'b1);
        kc = ka;
        ag = age_at(ka);
        if (age_at(kb) < ag) begin
          kc = kb;
          ag = age_at(kb);
        end
        if (ag < best_age) begin
          best_p = p;
          best_k = kc;
          best_age = ag;
        end
      end
      if (b.resolved_target != 0) begin
        shadow_valid[best_k] = 1'b1;
        shadow_tag[best_k] = tag_for(best_p, b.fetch_address);
        shadow_kind[best_k] = kd;
        shadow_tgt[best_k] = b.resolved_target;
        shadow_age[best_k] = age_count;
      end
    end
    age_count++;
    return r;
  endfunction

  function automatic opbtb_in_t make_beat(bit fn, logic [63:0] ip, logic [2:0] kd,
                                          logic [63:0] tgt, bit tk);
    opbtb_in_t b;
    b.func = fn;
    b.fetch_address = ip;
    b.branch_kind = kd;
    b.resolved_target = tgt;
    b.was_taken = tk;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: offer queued beats, idling at random outside the quiet stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
          in_data_i <= pending_beats[0];
          expected_results.insert(expected_results.size(), predict_btb(pending_beats[0]));
          void'(pending_beats.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: sink readiness and result comparison.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o.predicted_target !== expected_results[0].predicted_target) begin
            $display("%0t: target expected %h actual %h", $time,
                     expected_results[0].predicted_target, out_data_o.predicted_target);
            errors++;
          end
          if (out_data_o.predicted_kind !== expected_results[0].predicted_kind) begin
            $display("%0t: kind expected %0d actual %0d", $time,
                     expected_results[0].predicted_kind, out_data_o.predicted_kind);
            errors++;
          end
          if (out_data_o.lookup_missed !== expected_results[0].lookup_missed) begin
            $display("%0t: missed expected %0b actual %0b", $time,
                     expected_results[0].lookup_missed, out_data_o.lookup_missed);
            errors++;
          end
          void'(expected_results.pop_front());
          checked++;
        end
      end
      out_ready_i <= !hold_sink && (quiet || $urandom_range(99) >= 35);
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [63:0] ip, tgt;
    logic [2:0]  kd;
    int          roll;
    for (int k = 0; k < TotalSets; k++) shadow_valid[k] = 1'b0;
    for (int k = 0; k < RasDepth; k++) ras_mem[k] = '0;
    for (int k = 0; k < CallSizes; k++) call_size[k] = 4'd4;
    ras_ptr = 0;
    age_count = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: misses, learned entries, calls and returns, zero targets, extremes.
    queue_beat(make_beat(1'b0, 64'h1000, KindCond, '0, 1'b0));
    queue_beat(make_beat(1'b1, 64'h1000, KindCond, 64'h1000, 1'b1));
    queue_beat(make_beat(1'b0, 64'h1000, KindCond, '0, 1'b0));
    queue_beat(make_beat(1'b1, 64'h2000, 3'd1, '0, 1'b1));
    queue_beat(make_beat(1'b1, 64'h1000, 3'd2, '0, 1'b1));
    queue_beat(make_beat(1'b0, 64'h1000, KindNone, '0, 1'b0));
    queue_beat(make_beat(1'b1, 64'h3000, KindCall, 64'h9000_0000, 1'b1));
    queue_beat(make_beat(1'b0, 64'h3000, KindNone, '0, 1'b0));
    queue_beat(make_beat(1'b1, 64'h9100, KindReturn, 64'h3004, 1'b1));
    queue_beat(make_beat(1'b0, 64'h3000, KindNone, '0, 1'b0));
    queue_beat(make_beat(1'b0, 64'h9100, KindNone, '0, 1'b0));
    queue_beat(make_beat(1'b1, 64'h9100, KindReturn, 64'h3008, 1'b0));
    queue_beat(make_beat(1'b1, '1, 3'd7, '1, 1'b1));
    queue_beat(make_beat(1'b0, '1, 3'd7, '1, 1'b1));
    queue_beat(make_beat(1'b1, '1, 3'd7, 64'h4, 1'b1));
    queue_beat(make_beat(1'b1, 64'h0800_0000_0000_0000, KindIndCall, 64'h1, 1'b1));
    queue_beat(make_beat(1'b0, 64'h0, KindIndCall, '0, 1'b0));
    for (int i = 0; i < 4; i++)
      queue_beat(make_beat(1'b1, 64'h5000 + 64'(i) * 64'h800, KindCond, 64'h5100, 1'b1));
    queue_beat(make_beat(1'b0, 64'h5000, KindCond, '0, 1'b0));
    wait (pending_beats.size() == 0 && expected_results.size() == 0);

    // Sender pause until drained, then the receiver holds off while beats pile up.
    hold_sink = 1'b1;
    for (int i = 0; i < 6; i++)
      queue_beat(make_beat(1'(i), 64'h7000, KindCall, 64'h7400, 1'b1));
    repeat (300) @(posedge clk_i);
    hold_sink = 1'b0;

    // Random: mostly reused addresses so entries and the return stack are exercised.
    for (int i = 0; i < RandomBeats; i++) begin
      if (i == 400) quiet = 1'b1;
      if (i == 550) quiet = 1'b0;
      roll = $urandom_range(99);
      if (roll < 10) ip = rand64();
      else if (roll < 25) ip = 64'($urandom_range(63)) << 59 | 64'($urandom_range(255)) << 2;
      else ip = 64'($urandom_range(47)) << 2 | 64'h4_0000;
      kd = 3'($urandom_range(7));
      roll = $urandom_range(99);
      if (roll < 10) tgt = rand64();
      else if (roll < 15) tgt = '0;
      else if (kd == KindReturn) tgt = 64'h4_0000 + 64'($urandom_range(200));
      else tgt = ip ^ (64'($urandom()) >> $urandom_range(63));
      queue_beat(make_beat(1'($urandom_range(1)), ip, kd, tgt, $urandom_range(99) < 75));
    end
    wait (pending_beats.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk_i);

    $display("Checked %0d results over directed lookups, calls, returns and random beats.",
             checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/opbtb_pkg.sv
design/opbtb_entry_ram.sv
design/offset_partitioned_branch_target_buffer.sv
verif/tb_offset_partitioned_branch_target_buffer.sv
